/* src/bbd_pkg.sv */
// bbd_pkg: shared types, constants and helpers of the bilinear bayer demosaic
// used by bbd_interp and bayer_bilinear_demosaic_core; depends on nothing
package bbd_pkg;

   // frame size limits and derived widths
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MIN_DIM    = 2;
   localparam int CSR_W      = 12;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WID_W      = COL_W + 1;
   localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
   localparam int PIX_W      = 8;

   // reset values of the registers
   localparam logic [CSR_W-1:0] RESET_WIDTH  = CSR_W'(640);
   localparam logic [CSR_W-1:0] RESET_HEIGHT = CSR_W'(480);

   // reciprocal for the divide by three of sums below 2048
   localparam int DIV3_MUL   = 683;
   localparam int DIV3_SHIFT = 11;

   // register indexes of the csr port
   typedef enum logic [1:0] {
      CSR_PATTERN = 2'd0,
      CSR_WIDTH   = 2'd1,
      CSR_HEIGHT  = 2'd2
   } csr_index_type;

   // mosaic orders of the pattern register
   typedef enum logic [1:0] {
      PAT_RGGB = 2'd0,
      PAT_GRBG = 2'd1,
      PAT_GBRG = 2'd2,
      PAT_BGGR = 2'd3
   } pattern_type;

   // site classes of a pixel in the mosaic
   typedef enum logic [1:0] {
      CLS_RED      = 2'd0,  // red site
      CLS_GREEN_BV = 2'd1,  // green site, blue above and below
      CLS_GREEN_BH = 2'd2,  // green site, blue left and right
      CLS_BLUE     = 2'd3   // blue site
   } cls_type;

   typedef struct packed {
      logic [PIX_W-1:0] sample;
      logic             flush;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             frame_end;
   } rsp_word_type;

   // neighborhood flags of the pixel being finished
   typedef struct packed {
      logic    up;
      logic    dn;
      logic    lf;
      logic    rt;
      cls_type cls;
      logic    last;
   } site_type;

   // phase code of each mosaic order: bit 0 column phase, bit 1 row phase
   function automatic logic [1:0] pattern_code(input logic [1:0] pattern);
      logic [1:0] code;
      case (pattern)
         PAT_RGGB: code = 2'd2;
         PAT_GRBG: code = 2'd3;
         PAT_GBRG: code = 2'd0;
         PAT_BGGR: code = 2'd1;
         default:  code = 2'd2;
      endcase
      return code;
   endfunction

   // effective width, clamped to the supported range
   function automatic logic [WID_W-1:0] clamp_width(input logic [CSR_W-1:0] v);
      logic [WID_W-1:0] res;
      if (int'(v) < MIN_DIM) res = WID_W'(MIN_DIM);
      else if (int'(v) > MAX_WIDTH) res = WID_W'(MAX_WIDTH);
      else res = WID_W'(v);
      return res;
   endfunction

   // effective height, clamped to the supported range
   function automatic logic [ROW_W-1:0] clamp_height(input logic [CSR_W-1:0] v);
      logic [ROW_W-1:0] res;
      if (int'(v) < MIN_DIM) res = ROW_W'(MIN_DIM);
      else if (int'(v) > MAX_HEIGHT) res = ROW_W'(MAX_HEIGHT);
      else res = ROW_W'(v);
      return res;
   endfunction

   // truncating divide by three of a 10 bit sum whose quotient fits a pixel
   function automatic logic [PIX_W-1:0] div3(input logic [9:0] v);
      logic [20:0] prod;
      prod = 21'(v) * 21'(DIV3_MUL);
      return prod[DIV3_SHIFT+PIX_W-1:DIV3_SHIFT];
   endfunction

endpackage

/* src/bbd_interp.sv */
// bbd_interp: bilinear interpolation of one pixel from a 3x3 raw window
// depends on bbd_pkg (site_type, rsp_word_type, div3)
module bbd_interp (
   input  logic [2:0][2:0][bbd_pkg::PIX_W-1:0] win,
   input  bbd_pkg::site_type                   site,
   output bbd_pkg::rsp_word_type               pixel
);

   logic [bbd_pkg::PIX_W-1:0] ctr;
   logic [9:0]                dt;
   logic [8:0]                ht;
   logic [8:0]                vt;
   logic [9:0]                ot;
   logic [9:0]                gs;
   logic                      nh;
   logic                      nv;
   logic [1:0]                dsh;
   logic [9:0]                dq;
   logic [bbd_pkg::PIX_W-1:0] diag;
   logic [bbd_pkg::PIX_W-1:0] horz;
   logic [bbd_pkg::PIX_W-1:0] vert;
   logic [bbd_pkg::PIX_W-1:0] orth;
   logic [bbd_pkg::PIX_W-1:0] grn;

   // masked neighbor sums
   always_comb begin
      ctr = win[1][1];
      nh  = site.lf & site.rt;
      nv  = site.up & site.dn;
      dt  = ((site.up & site.lf) ? 10'(win[0][0]) : 10'd0)
          + ((site.up & site.rt) ? 10'(win[0][2]) : 10'd0)
          + ((site.dn & site.lf) ? 10'(win[2][0]) : 10'd0)
          + ((site.dn & site.rt) ? 10'(win[2][2]) : 10'd0);
      ht  = (site.lf ? 9'(win[1][0]) : 9'd0) + (site.rt ? 9'(win[1][2]) : 9'd0);
      vt  = (site.up ? 9'(win[0][1]) : 9'd0) + (site.dn ? 9'(win[2][1]) : 9'd0);
      ot  = 10'(ht) + 10'(vt);
      gs  = 10'(ctr) + dt;
   end

   // means: diagonal count is 1, 2 or 4, so it is a shift
   always_comb begin
      dsh  = {1'b0, nh} + {1'b0, nv};
      dq   = dt >> dsh;
      diag = dq[bbd_pkg::PIX_W-1:0];
      horz = nh ? ht[8:1] : ht[7:0];
      vert = nv ? vt[8:1] : vt[7:0];
      // orthogonal count is 2, 3 or 4
      if (nh & nv) orth = ot[9:2];
      else if (!nh & !nv) orth = ot[8:1];
      else orth = bbd_pkg::div3(ot);
      // green site: centre if four diagonals, else mean with present ones
      if (nh & nv) grn = ctr;
      else if (nh ^ nv) grn = bbd_pkg::div3(gs);
      else grn = gs[8:1];
   end

   // pick channels by site class
   always_comb begin
      pixel.frame_end = site.last;
      case (site.cls)
         bbd_pkg::CLS_RED: begin
            pixel.blue  = diag;
            pixel.green = orth;
            pixel.red   = ctr;
         end
         bbd_pkg::CLS_GREEN_BV: begin
            pixel.blue  = vert;
            pixel.green = grn;
            pixel.red   = horz;
         end
         bbd_pkg::CLS_GREEN_BH: begin
            pixel.blue  = horz;
            pixel.green = grn;
            pixel.red   = vert;
         end
         default: begin
            pixel.blue  = ctr;
            pixel.green = orth;
            pixel.red   = diag;
         end
      endcase
   end

endmodule

/* src/bayer_bilinear_demosaic_core.sv */
// bayer_bilinear_demosaic_core: streaming bilinear demosaic, top level
// depends on bbd_pkg and bbd_interp
//
// Usage: raw samples enter in raster order on the req channel, one word per
// sample (flush = 0). A pixel leaves on the rsp channel as blue, green and red
// once the sample one row and one column past it has arrived; after the last
// sample of a frame, frame_width + 1 flush words push out the rest, and the
// final pixel carries frame_end. A flush while samples are still due is taken
// and dropped. Both channels use valid/stall; a word moves when valid is high
// and stall is low.
// Throughput: one word per cycle while the rsp channel is not stalled. Each
// word reads the two line stores once and writes them once, one port each,
// and that sets the rate. Path: a word that finishes a pixel passes the read
// stage, the window stage and the output register before rsp_valid shows it.
// Stall: a held result stays in the output register; the stages behind it
// keep taking words until they are full, then req_stall rises.
// Reset: counters, window and registers return to their defaults (RGGB,
// 640 x 480); the line stores are not cleared, as entries are only read
// after being written or for neighbors outside the frame, which are masked.
// The user must write registers only while the block is idle; the block itself does not enforce it.
module bayer_bilinear_demosaic_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bbd_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bbd_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [bbd_pkg::CSR_W-1:0]     csr_wdata
);

   typedef struct packed {
      logic [bbd_pkg::PIX_W-1:0] val;
      logic [bbd_pkg::COL_W-1:0] x;
      logic                      emit;
      bbd_pkg::site_type         site;
   } s1_type;

   typedef struct packed {
      logic              emit;
      bbd_pkg::site_type site;
   } s2_type;

   // configuration registers
   logic [1:0]                pattern_ff;
   logic [bbd_pkg::CSR_W-1:0] width_ff;
   logic [bbd_pkg::CSR_W-1:0] height_ff;

   // position counters
   logic [bbd_pkg::COL_W-1:0] in_col_ff,  in_col_in;
   logic [bbd_pkg::ROW_W-1:0] in_row_ff,  in_row_in;
   logic [bbd_pkg::COL_W-1:0] out_col_ff, out_col_in;
   logic [bbd_pkg::ROW_W-1:0] out_row_ff, out_row_in;

   // pipeline
   logic                  s1_valid_ff, s1_valid_in;
   s1_type                s1_ff, s1_in;
   logic                  s2_valid_ff, s2_valid_in;
   s2_type                s2_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   bbd_pkg::rsp_word_type rsp_word_ff;
   logic [bbd_pkg::PIX_W-1:0] up_rd_ff;
   logic [bbd_pkg::PIX_W-1:0] mid_rd_ff;
   logic [2:0][2:0][bbd_pkg::PIX_W-1:0] win_ff, win_in;

   logic [bbd_pkg::PIX_W-1:0] upper_mem  [bbd_pkg::MAX_WIDTH];
   logic [bbd_pkg::PIX_W-1:0] middle_mem [bbd_pkg::MAX_WIDTH];

   // accept-side decode
   logic [bbd_pkg::WID_W-1:0] w_eff;
   logic [bbd_pkg::ROW_W-1:0] h_eff;
   logic                      taking;
   logic                      drop;
   logic                      accept;
   logic                      enter;
   logic [bbd_pkg::COL_W-1:0] col0;
   logic [bbd_pkg::WID_W-1:0] col_inc;
   logic [bbd_pkg::WID_W-1:0] ocol_inc;
   logic [bbd_pkg::ROW_W:0]   orow_inc;
   logic                      emit;
   logic [1:0]                code;
   logic                      bx;
   logic                      by;
   bbd_pkg::site_type         site;

   // handshake between stages
   logic                  out_free;
   logic                  s2_go;
   logic                  s2_take;
   logic                  s1_go;
   logic                  fwd;
   bbd_pkg::rsp_word_type pixel;

   // stage flow control
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s2_go     = s2_valid_ff && (!s2_ff.emit || out_free);
      s2_take   = !s2_valid_ff || s2_go;
      s1_go     = s1_valid_ff && s2_take;
      req_stall = s1_valid_ff && !s2_take;
      accept    = req_valid && !req_stall;
   end

   // decode of the incoming word against the counters
   always_comb begin
      w_eff    = bbd_pkg::clamp_width(width_ff);
      h_eff    = bbd_pkg::clamp_height(height_ff);
      taking   = in_row_ff < h_eff;
      drop     = req_word.flush && taking;
      enter    = accept && !drop;
      col0     = ({1'b0, in_col_ff} >= w_eff) ? '0 : in_col_ff;
      col_inc  = {1'b0, col0} + bbd_pkg::WID_W'(1);
      emit     = (in_row_ff >= bbd_pkg::ROW_W'(2))
              || (in_row_ff == bbd_pkg::ROW_W'(1) && col0 != '0);
      ocol_inc = {1'b0, out_col_ff} + bbd_pkg::WID_W'(1);
      orow_inc = {1'b0, out_row_ff} + (bbd_pkg::ROW_W+1)'(1);
      code     = bbd_pkg::pattern_code(pattern_ff);
      bx       = code[0];
      by       = code[1] ^ h_eff[0];
      site.up   = out_row_ff != '0;
      site.dn   = orow_inc < {1'b0, h_eff};
      site.lf   = out_col_ff != '0;
      site.rt   = ocol_inc < w_eff;
      site.cls  = bbd_pkg::cls_type'({out_row_ff[0] ^ by, out_col_ff[0] ^ bx});
      site.last = !site.rt && !site.dn;
   end

   // counter next state
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (enter) begin
         if (col_inc >= w_eff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + bbd_pkg::ROW_W'(1);
         end else begin
            in_col_in = col_inc[bbd_pkg::COL_W-1:0];
         end
         if (emit) begin
            if (site.last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (!site.rt) begin
               out_col_in = '0;
               out_row_in = orow_inc[bbd_pkg::ROW_W-1:0];
            end else begin
               out_col_in = ocol_inc[bbd_pkg::COL_W-1:0];
            end
         end
      end
   end

   // stage 1 contents, the valid bits of every stage and the forward select
   always_comb begin
      s1_in.val   = taking ? req_word.sample : '0;
      s1_in.x     = col0;
      s1_in.emit  = emit;
      s1_in.site  = site;
      s1_valid_in = enter ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s2_valid_in = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
      if (s2_go && s2_ff.emit) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
      fwd = s1_go && (s1_ff.x == col0);
   end

   // window shift: new column from the two line stores and the new sample
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = up_rd_ff;
      win_in[1][2] = mid_rd_ff;
      win_in[2][2] = s1_ff.val;
   end

   bbd_interp u_interp (
      .win   (win_ff),
      .site  (s2_ff.site),
      .pixel (pixel)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= bbd_pkg::PAT_RGGB;
         width_ff     <= bbd_pkg::RESET_WIDTH;
         height_ff    <= bbd_pkg::RESET_HEIGHT;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               bbd_pkg::CSR_PATTERN: pattern_ff <= csr_wdata[1:0];
               bbd_pkg::CSR_WIDTH:   width_ff   <= csr_wdata;
               bbd_pkg::CSR_HEIGHT:  height_ff  <= csr_wdata;
               default: ;
            endcase
         end
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) win_ff <= win_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (enter) s1_ff <= s1_in;
      if (s1_go) begin
         s2_ff.emit <= s1_ff.emit;
         s2_ff.site <= s1_ff.site;
      end
      if (s2_go && s2_ff.emit) rsp_word_ff <= pixel;
   end

   // line stores: write back the shifted column, read for the next word
   always_ff @(posedge clock) begin
      if (s1_go) begin
         upper_mem[s1_ff.x]  <= mid_rd_ff;
         middle_mem[s1_ff.x] <= s1_ff.val;
      end
      if (enter) begin
         if (fwd) begin
            up_rd_ff  <= mid_rd_ff;
            mid_rd_ff <= s1_ff.val;
         end else begin
            up_rd_ff  <= upper_mem[col0];
            mid_rd_ff <= middle_mem[col0];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // stall only while stage 1 holds a word
   a_stall_needs_s1 : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall raised with stage 1 empty");

   // end of frame returns every counter to the origin
   a_frame_end_clears : assert property (@(posedge clock) disable iff (reset)
      (enter && emit && site.last) |=>
         (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("counters not cleared after the last pixel");

   // a finished pixel always lands in the output register
   a_emit_lands : assert property (@(posedge clock) disable iff (reset)
      (s2_go && s2_ff.emit) |=> rsp_valid_ff)
      else $error("emitted pixel lost");

   // a taken result with nothing behind it empties the output
   a_rsp_drains : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !(s2_go && s2_ff.emit)) |=> !rsp_valid_ff)
      else $error("result repeated");

endmodule
